// File: rtl/core/mgc_pkg.sv
package mgc_pkg;

	localparam int POS_W     = 5;
	localparam int MOM_W     = 32;
	localparam int SIZE_W    = 6;
	localparam int INV_W     = 32;
	localparam int CURL_W    = 40;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int COORD_W   = 7;
	localparam int DERIV_W   = 49;
	localparam int MAC_A_W   = 48;
	localparam int MAC_B_W   = 40;
	localparam int ACC_W     = 80;
	localparam int ROOT_W    = 40;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INV_Z  = 3'd5;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic signed [CURL_W-1:0] CURL_MAX = {1'b0, {(CURL_W-1){1'b1}}};
	localparam logic signed [CURL_W-1:0] CURL_MIN = {1'b1, {(CURL_W-1){1'b0}}};

	typedef struct packed {
		logic             start;
		logic [MOM_W-1:0] num;
		logic [MOM_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic               start;
		logic               clear;
		logic [MAC_A_W-1:0] a;
		logic [MAC_B_W-1:0] b;
	} mac_req_t;

	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] rad;
	} sqrt_req_t;

	// Axis along which each of the six curl terms differentiates
	function automatic logic [1:0] term_axis(input logic [2:0] k);
		case (k)
			3'd0: return AXIS_Y;
			3'd1: return AXIS_Z;
			3'd2: return AXIS_Z;
			3'd3: return AXIS_X;
			3'd4: return AXIS_X;
			3'd5: return AXIS_Y;
			default: return AXIS_X;
		endcase
	endfunction

	// Velocity component that each curl term differentiates
	function automatic logic [1:0] term_comp(input logic [2:0] k);
		case (k)
			3'd0: return AXIS_Z;
			3'd1: return AXIS_Y;
			3'd2: return AXIS_X;
			3'd3: return AXIS_Z;
			3'd4: return AXIS_Y;
			3'd5: return AXIS_X;
			default: return AXIS_X;
		endcase
	endfunction

endpackage

// File: rtl/core/mgc_cmd_if.sv
interface mgc_cmd_if;
	import mgc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     action;
	logic [POS_W-1:0]         pos_x;
	logic [POS_W-1:0]         pos_y;
	logic [POS_W-1:0]         pos_z;
	logic signed [MOM_W-1:0]  mom_x;
	logic signed [MOM_W-1:0]  mom_y;
	logic signed [MOM_W-1:0]  mom_z;
	logic [MOM_W-1:0]         energy;

	modport source (output valid, action, pos_x, pos_y, pos_z, mom_x, mom_y, mom_z, energy,
		input ready);
	modport sink (input valid, action, pos_x, pos_y, pos_z, mom_x, mom_y, mom_z, energy,
		output ready);
endinterface

// File: rtl/core/mgc_res_if.sv
interface mgc_res_if;
	import mgc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [CURL_W-1:0] curl_x;
	logic signed [CURL_W-1:0] curl_y;
	logic signed [CURL_W-1:0] curl_z;
	logic [CURL_W-1:0]        curl_mag;
	logic                     clipped;

	modport source (output valid, curl_x, curl_y, curl_z, curl_mag, clipped, input ready);
	modport sink (input valid, curl_x, curl_y, curl_z, curl_mag, clipped, output ready);
endinterface

// File: rtl/core/mgc_div.sv
module mgc_div #(
	parameter int FRAC = 30
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mgc_pkg::div_req_t req,
	output logic              done,
	output logic [FRAC:0]     quo
);
	import mgc_pkg::*;

	localparam int CNT_W = $clog2(FRAC + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MOM_W-1:0] rem_q;
	logic [MOM_W-1:0] den_q;
	logic [FRAC:0]    quo_q;
	logic [MOM_W:0]   trial;
	logic             take;

	assign trial = {rem_q, 1'b0};
	assign take  = trial >= {1'b0, den_q};
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				den_q <= req.den;
				cnt_q <= '0;
				// cap at exactly one when the quotient would reach it
				if (req.num >= req.den) begin
					quo_q  <= (FRAC+1)'(1) << FRAC;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					quo_q  <= '0;
					rem_q  <= req.num;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				rem_q <= take ? MOM_W'(trial - {1'b0, den_q}) : trial[MOM_W-1:0];
				quo_q <= {quo_q[FRAC-1:0], take};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(FRAC - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

// File: rtl/core/mgc_mac.sv
module mgc_mac (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mgc_pkg::mac_req_t        req,
	output logic                     done,
	output logic [mgc_pkg::ACC_W-1:0] acc
);
	import mgc_pkg::*;

	localparam int CNT_W = $clog2(MAC_B_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ACC_W-1:0]   a_q;
	logic [MAC_B_W-1:0] b_q;
	logic [ACC_W-1:0]   acc_q;

	assign done = done_q;
	assign acc  = acc_q;

	// one multiplier bit per cycle, least significant first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				a_q    <= ACC_W'(req.a);
				b_q    <= req.b;
				cnt_q  <= '0;
				busy_q <= 1'b1;
				if (req.clear) begin
					acc_q <= '0;
				end
			end else if (busy_q) begin
				if (b_q[0]) begin
					acc_q <= acc_q + a_q;
				end
				a_q   <= a_q << 1;
				b_q   <= b_q >> 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MAC_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

// File: rtl/core/mgc_sqrt.sv
module mgc_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mgc_pkg::sqrt_req_t         req,
	output logic                       done,
	output logic [mgc_pkg::ROOT_W-1:0] root
);
	import mgc_pkg::*;

	localparam int REM_W = ROOT_W + 3;
	localparam int CNT_W = $clog2(ROOT_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ACC_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  cur;
	logic [REM_W-1:0]  trial;
	logic              take;

	assign cur   = {rem_q[REM_W-3:0], rad_q[ACC_W-1 -: 2]};
	assign trial = REM_W'({root_q, 2'b01});
	assign take  = cur >= trial;
	assign done  = done_q;
	assign root  = root_q;

	// two radicand bits per cycle, one root bit out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rad_q  <= req.rad;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rad_q  <= rad_q << 2;
				rem_q  <= take ? cur - trial : cur;
				root_q <= {root_q[ROOT_W-2:0], take};
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

// File: rtl/core/masked_grid_curl.sv
// Velocity grid with a masked finite-difference curl. A load beat writes one cell: each
// momentum component is divided by the cell energy in a bit-serial restoring divider
// (one quotient bit a cycle, shared by the three components), the velocity saturates at
// plus or minus one, and a nonzero energy marks the cell occupied. An evaluate beat reads
// the centre and six neighbours through the one read port of the cell memory (a read
// state and a capture state each), forms six derivatives on a bit-serial shift-add
// multiplier (skipped for a derivative with no occupied neighbour), then the three squares
// on the same multiplier and a two-bit-a-cycle square root. A load is shorter where a
// component caps at one and skips the divider for zero energy; an evaluate's time is set
// mainly by the multiplier, and a boundary or empty cell finishes without it.
// One item is in work at a time; a finished result waits in the output register while
// the next item is taken. After reset a clearing pass walks all 2^(3*clog2(GRID_DIM))
// memory words (32768 by default), one a cycle, before the first item is accepted;
// configuration writes are taken during it.
module masked_grid_curl #(
	parameter int GRID_DIM  = 32,
	parameter int VEL_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mgc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mgc_pkg::CFG_W-1:0]       cfg_data,
	mgc_cmd_if.sink                         cmd,
	mgc_res_if.source                       res
);
	import mgc_pkg::*;

	localparam int FRAC    = VEL_WIDTH - 2;
	localparam int AW      = $clog2(GRID_DIM);
	localparam int ADDR_W  = 3 * AW;
	localparam int CELLS   = 1 << ADDR_W;
	localparam int WORD_W  = 3 * VEL_WIDTH + 1;
	localparam int OCC_BIT = 3 * VEL_WIDTH;
	localparam int BASE_SH = FRAC - 14;
	localparam logic [COORD_W-1:0] GRID_LIM = COORD_W'(GRID_DIM);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LD_DIV, S_LD_RUN, S_LD_WR, S_EV_RD, S_EV_CAP,
		S_DV_SET, S_DV_RUN, S_CURL, S_SQ_SET, S_SQ_RUN, S_RT_RUN, S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [INV_W-1:0]  inv_x_q, inv_y_q, inv_z_q;

	// item in work
	logic [ADDR_W-1:0]       clr_addr_q;
	logic [AW-1:0]           px_q, py_q, pz_q;
	logic signed [MOM_W-1:0] mom_q [3];
	logic [MOM_W-1:0]        energy_q;
	logic [VEL_WIDTH-1:0]    vel_q [3];
	logic [1:0]              comp_q;
	logic [2:0]              rd_idx_q;
	logic [WORD_W-1:0]       nb_q [7];
	logic [2:0]              term_q;
	logic signed [DERIV_W-1:0] d_q [6];
	logic                    neg_q;
	logic                    half_q;
	logic signed [CURL_W-1:0] cur_q [3];
	logic                    clip_q;
	logic                    zero_q;
	logic [1:0]              sq_q;

	div_req_t  div_req_q;
	mac_req_t  mac_req_q;
	sqrt_req_t sqrt_req_q;
	logic              div_done, mac_done, sqrt_done;
	logic [FRAC:0]     div_quo;
	logic [ACC_W-1:0]  mac_acc;
	logic [ROOT_W-1:0] sqrt_root;

	// cell memory: {occupied, vel_z, vel_y, vel_x}
	logic [WORD_W-1:0] mem [CELLS];
	logic [WORD_W-1:0] rd_word_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;

	logic [COORD_W-1:0] pxe, pye, pze;
	logic               in_grid;
	logic               in_interior;

	function automatic logic interior(input logic [COORD_W-1:0] p,
		input logic [SIZE_W-1:0] s);
		logic [COORD_W-1:0] se;
		logic [COORD_W-1:0] eff;
		se  = COORD_W'(s);
		eff = (se > GRID_LIM) ? GRID_LIM : se;
		return (p != '0) && (p + 1'b1 < eff);
	endfunction

	function automatic logic [VEL_WIDTH-1:0] field(input logic [WORD_W-1:0] w,
		input logic [1:0] c);
		case (c)
			AXIS_X:  return w[VEL_WIDTH-1:0];
			AXIS_Y:  return w[2*VEL_WIDTH-1:VEL_WIDTH];
			AXIS_Z:  return w[3*VEL_WIDTH-1:2*VEL_WIDTH];
			default: return w[VEL_WIDTH-1:0];
		endcase
	endfunction

	function automatic logic signed [CURL_W-1:0] sat(input logic signed [DERIV_W:0] v);
		if (v > (DERIV_W+1)'(CURL_MAX)) begin
			return CURL_MAX;
		end else if (v < (DERIV_W+1)'(CURL_MIN)) begin
			return CURL_MIN;
		end
		return v[CURL_W-1:0];
	endfunction

	function automatic logic clips(input logic signed [DERIV_W:0] v);
		return (v > (DERIV_W+1)'(CURL_MAX)) || (v < (DERIV_W+1)'(CURL_MIN));
	endfunction

	assign pxe = COORD_W'(cmd.pos_x);
	assign pye = COORD_W'(cmd.pos_y);
	assign pze = COORD_W'(cmd.pos_z);
	assign in_grid = (pxe < GRID_LIM) && (pye < GRID_LIM) && (pze < GRID_LIM);
	assign in_interior = interior(pxe, size_x_q) && interior(pye, size_y_q)
		&& interior(pze, size_z_q);

	assign cmd.ready = (state_q == S_IDLE);

	// divider operands
	logic signed [MOM_W-1:0] mom_sel;
	logic [MOM_W-1:0]        mom_abs;
	logic [VEL_WIDTH-1:0]    quo_ext;
	assign mom_sel = mom_q[comp_q];
	assign mom_abs = mom_sel[MOM_W-1] ? MOM_W'(~mom_sel + 1'b1) : mom_sel;
	assign quo_ext = VEL_WIDTH'(div_quo);

	// derivative operands
	logic [1:0]               dv_axis, dv_comp;
	logic [2:0]               up_idx, lo_idx;
	logic [WORD_W-1:0]        up_w, lo_w;
	logic [VEL_WIDTH-1:0]     vu, vl, vc;
	logic                     ou, ol;
	logic signed [VEL_WIDTH:0] diff;
	logic [VEL_WIDTH-1:0]     dmag;
	logic [INV_W-1:0]         inv_sel;
	logic [ACC_W-1:0]         acc_sh;
	logic [DERIV_W-1:0]       dval;

	always_comb begin
		dv_axis = term_axis(term_q);
		dv_comp = term_comp(term_q);
		up_idx  = {dv_axis, 1'b0} + 3'd1;
		lo_idx  = {dv_axis, 1'b0} + 3'd2;
		up_w    = nb_q[up_idx];
		lo_w    = nb_q[lo_idx];
		vu      = field(up_w, dv_comp);
		vl      = field(lo_w, dv_comp);
		vc      = field(nb_q[0], dv_comp);
		ou      = up_w[OCC_BIT];
		ol      = lo_w[OCC_BIT];
		if (ou && ol) begin
			diff = $signed({vu[VEL_WIDTH-1], vu}) - $signed({vl[VEL_WIDTH-1], vl});
		end else if (ou) begin
			diff = $signed({vu[VEL_WIDTH-1], vu}) - $signed({vc[VEL_WIDTH-1], vc});
		end else begin
			diff = $signed({vc[VEL_WIDTH-1], vc}) - $signed({vl[VEL_WIDTH-1], vl});
		end
		dmag = diff[VEL_WIDTH] ? VEL_WIDTH'(-diff) : diff[VEL_WIDTH-1:0];
		case (dv_axis)
			AXIS_X:  inv_sel = inv_x_q;
			AXIS_Y:  inv_sel = inv_y_q;
			AXIS_Z:  inv_sel = inv_z_q;
			default: inv_sel = inv_x_q;
		endcase
		acc_sh = (mac_acc >> BASE_SH) >> half_q;
		dval   = {1'b0, acc_sh[DERIV_W-2:0]};
	end

	// squaring operand
	logic signed [CURL_W-1:0] sq_sel;
	logic [CURL_W-1:0]        sq_abs;
	assign sq_sel = cur_q[sq_q];
	assign sq_abs = sq_sel[CURL_W-1] ? CURL_W'(-sq_sel) : sq_sel;

	// curl terms
	logic signed [DERIV_W:0] cx, cy, cz;
	assign cx = $signed({d_q[0][DERIV_W-1], d_q[0]}) - $signed({d_q[1][DERIV_W-1], d_q[1]});
	assign cy = $signed({d_q[2][DERIV_W-1], d_q[2]}) - $signed({d_q[3][DERIV_W-1], d_q[3]});
	assign cz = $signed({d_q[4][DERIV_W-1], d_q[4]}) - $signed({d_q[5][DERIV_W-1], d_q[5]});

	// memory ports
	always_comb begin
		mem_we    = (state_q == S_CLEAR) || (state_q == S_LD_WR);
		mem_waddr = (state_q == S_CLEAR) ? clr_addr_q : {pz_q, py_q, px_q};
		mem_wdata = (state_q == S_CLEAR) ? '0
			: {(energy_q != '0), vel_q[2], vel_q[1], vel_q[0]};
		case (rd_idx_q)
			3'd1:    mem_raddr = {pz_q, py_q, AW'(px_q + 1'b1)};
			3'd2:    mem_raddr = {pz_q, py_q, AW'(px_q - 1'b1)};
			3'd3:    mem_raddr = {pz_q, AW'(py_q + 1'b1), px_q};
			3'd4:    mem_raddr = {pz_q, AW'(py_q - 1'b1), px_q};
			3'd5:    mem_raddr = {AW'(pz_q + 1'b1), py_q, px_q};
			3'd6:    mem_raddr = {AW'(pz_q - 1'b1), py_q, px_q};
			default: mem_raddr = {pz_q, py_q, px_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_word_q <= mem[mem_raddr];
	end

	// configuration registers; an index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_W'(32);
			size_y_q <= SIZE_W'(32);
			size_z_q <= SIZE_W'(32);
			inv_x_q  <= INV_W'(65536);
			inv_y_q  <= INV_W'(65536);
			inv_z_q  <= INV_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIZE_X: size_x_q <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Y: size_y_q <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Z: size_z_q <= cfg_data[SIZE_W-1:0];
				REG_INV_X:  inv_x_q  <= cfg_data[INV_W-1:0];
				REG_INV_Y:  inv_y_q  <= cfg_data[INV_W-1:0];
				REG_INV_Z:  inv_z_q  <= cfg_data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer; each start request is high for one cycle, dropped in the state after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_addr_q   <= '0;
			px_q         <= '0;
			py_q         <= '0;
			pz_q         <= '0;
			energy_q     <= '0;
			comp_q       <= '0;
			rd_idx_q     <= '0;
			term_q       <= '0;
			neg_q        <= 1'b0;
			half_q       <= 1'b0;
			clip_q       <= 1'b0;
			zero_q       <= 1'b0;
			sq_q         <= '0;
			div_req_q    <= '0;
			mac_req_q    <= '0;
			sqrt_req_q   <= '0;
			res.valid    <= 1'b0;
			res.curl_x   <= '0;
			res.curl_y   <= '0;
			res.curl_z   <= '0;
			res.curl_mag <= '0;
			res.clipped  <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				mom_q[i] <= '0;
				vel_q[i] <= '0;
				cur_q[i] <= '0;
			end
			for (int i = 0; i < 7; i++) begin
				nb_q[i] <= '0;
			end
			for (int i = 0; i < 6; i++) begin
				d_q[i] <= '0;
			end
		end else begin
			// drop a taken beat unless a new one replaces it below
			if (res.valid && res.ready && (state_q != S_OUT)) begin
				res.valid <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (&clr_addr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd.valid) begin
						px_q     <= pxe[AW-1:0];
						py_q     <= pye[AW-1:0];
						pz_q     <= pze[AW-1:0];
						mom_q[0] <= cmd.mom_x;
						mom_q[1] <= cmd.mom_y;
						mom_q[2] <= cmd.mom_z;
						energy_q <= cmd.energy;
						comp_q   <= '0;
						rd_idx_q <= '0;
						term_q   <= '0;
						zero_q   <= 1'b0;
						if (cmd.action == CMD_LOAD) begin
							// drop loads outside the grid; empty cells skip the divider
							if (in_grid) begin
								if (cmd.energy == '0) begin
									for (int i = 0; i < 3; i++) begin
										vel_q[i] <= '0;
									end
									state_q <= S_LD_WR;
								end else begin
									state_q <= S_LD_DIV;
								end
							end
						end else if (in_interior) begin
							state_q <= S_EV_RD;
						end else begin
							for (int i = 0; i < 3; i++) begin
								cur_q[i] <= '0;
							end
							clip_q  <= 1'b0;
							zero_q  <= 1'b1;
							state_q <= S_OUT;
						end
					end
				end
				S_LD_DIV: begin
					div_req_q <= '{start: 1'b1, num: mom_abs, den: energy_q};
					state_q   <= S_LD_RUN;
				end
				S_LD_RUN: begin
					div_req_q.start <= 1'b0;
					if (div_done) begin
						vel_q[comp_q] <= mom_sel[MOM_W-1] ? VEL_WIDTH'(-quo_ext) : quo_ext;
						if (comp_q == 2'd2) begin
							state_q <= S_LD_WR;
						end else begin
							comp_q  <= comp_q + 1'b1;
							state_q <= S_LD_DIV;
						end
					end
				end
				S_LD_WR: begin
					state_q <= S_IDLE;
				end
				S_EV_RD: begin
					state_q <= S_EV_CAP;
				end
				S_EV_CAP: begin
					nb_q[rd_idx_q] <= rd_word_q;
					if (rd_idx_q == 3'd6) begin
						if (nb_q[0][OCC_BIT]) begin
							state_q <= S_DV_SET;
						end else begin
							for (int i = 0; i < 3; i++) begin
								cur_q[i] <= '0;
							end
							clip_q  <= 1'b0;
							zero_q  <= 1'b1;
							state_q <= S_OUT;
						end
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
						state_q  <= S_EV_RD;
					end
				end
				S_DV_SET: begin
					if (!ou && !ol) begin
						// no occupied neighbour: derivative is zero
						d_q[term_q] <= '0;
						if (term_q == 3'd5) begin
							state_q <= S_CURL;
						end else begin
							term_q <= term_q + 1'b1;
						end
					end else begin
						mac_req_q <= '{start: 1'b1, clear: 1'b1, a: MAC_A_W'(dmag),
							b: MAC_B_W'(inv_sel)};
						neg_q   <= diff[VEL_WIDTH];
						half_q  <= ou && ol;
						state_q <= S_DV_RUN;
					end
				end
				S_DV_RUN: begin
					mac_req_q.start <= 1'b0;
					if (mac_done) begin
						d_q[term_q] <= neg_q ? DERIV_W'(-dval) : dval;
						if (term_q == 3'd5) begin
							state_q <= S_CURL;
						end else begin
							term_q  <= term_q + 1'b1;
							state_q <= S_DV_SET;
						end
					end
				end
				S_CURL: begin
					cur_q[0] <= sat(cx);
					cur_q[1] <= sat(cy);
					cur_q[2] <= sat(cz);
					clip_q   <= clips(cx) || clips(cy) || clips(cz);
					sq_q     <= '0;
					state_q  <= S_SQ_SET;
				end
				S_SQ_SET: begin
					mac_req_q <= '{start: 1'b1, clear: (sq_q == 2'd0), a: MAC_A_W'(sq_abs),
						b: MAC_B_W'(sq_abs)};
					state_q <= S_SQ_RUN;
				end
				S_SQ_RUN: begin
					mac_req_q.start <= 1'b0;
					if (mac_done) begin
						if (sq_q == 2'd2) begin
							sqrt_req_q <= '{start: 1'b1, rad: mac_acc};
							state_q    <= S_RT_RUN;
						end else begin
							sq_q    <= sq_q + 1'b1;
							state_q <= S_SQ_SET;
						end
					end
				end
				S_RT_RUN: begin
					sqrt_req_q.start <= 1'b0;
					if (sqrt_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (!res.valid || res.ready) begin
						res.valid    <= 1'b1;
						res.curl_x   <= cur_q[0];
						res.curl_y   <= cur_q[1];
						res.curl_z   <= cur_q[2];
						res.curl_mag <= zero_q ? '0 : sqrt_root;
						res.clipped  <= clip_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	mgc_div #(.FRAC(FRAC)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	mgc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req_q),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	mgc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sqrt_req_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);
endmodule

// File: rtl/core/mgc_checker.sv
module mgc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cmd_valid,
	input logic                             cmd_ready,
	input logic                             cmd_action,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic signed [mgc_pkg::CURL_W-1:0] curl_x,
	input logic signed [mgc_pkg::CURL_W-1:0] curl_y,
	input logic signed [mgc_pkg::CURL_W-1:0] curl_z,
	input logic [mgc_pkg::CURL_W-1:0]        curl_mag,
	input logic                             clipped
);
	import mgc_pkg::*;

	// a pending result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(curl_x) && $stable(curl_y)
			&& $stable(curl_z) && $stable(curl_mag) && $stable(clipped))
		else $error("result changed while stalled");

	// magnitude is zero exactly when every component is zero
	a_mag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((curl_mag == '0) == (curl_x == '0 && curl_y == '0 && curl_z == '0)))
		else $error("magnitude disagrees with components");

	// a clipped result has a component at a rail
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && clipped |-> (curl_x == CURL_MAX || curl_x == CURL_MIN
			|| curl_y == CURL_MAX || curl_y == CURL_MIN
			|| curl_z == CURL_MAX || curl_z == CURL_MIN))
		else $error("clipped without a saturated component");

	// a load beat raises no result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_action == CMD_LOAD && !res_valid |=> !res_valid)
		else $error("result appeared after a load");
endmodule

bind masked_grid_curl mgc_checker u_mgc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.cmd_action (cmd.action),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.curl_x     (res.curl_x),
	.curl_y     (res.curl_y),
	.curl_z     (res.curl_z),
	.curl_mag   (res.curl_mag),
	.clipped    (res.clipped)
);
